FILE: hdl/mono_lcd_framebuffer_dirty_flush_defines.svh
// Assertion helpers used by the frame buffer controller.
`ifndef MONO_LCD_FRAMEBUFFER_DIRTY_FLUSH_DEFINES_SVH
`define MONO_LCD_FRAMEBUFFER_DIRTY_FLUSH_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mlcd_pkg.sv
package mlcd_pkg;

  localparam int WORD_COUNT  = 512;
  localparam int ADDR_W      = 9;

  // Opcodes
  localparam logic [2:0] OP_PIXEL  = 3'd0;
  localparam logic [2:0] OP_HLINE  = 3'd1;
  localparam logic [2:0] OP_VLINE  = 3'd2;
  localparam logic [2:0] OP_INVERT = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_FLUSH  = 3'd5;
  localparam logic [2:0] OP_FORCE  = 3'd6;
  localparam logic [2:0] OP_TICK   = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_FUNCTION_SET = 2'd0;
  localparam logic [1:0] CFG_GDRAM_ADDR   = 2'd1;
  localparam logic [1:0] CFG_CLEAR_FILL   = 2'd2;

  localparam logic [7:0] SYNC_CMD  = 8'hf8;
  localparam logic [7:0] SYNC_DATA = 8'hfa;
  localparam logic [7:0] DISP_OFF_BITS = 8'h04;
  localparam logic [7:0] DISP_ON_BITS  = 8'h06;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic       value;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] sync_byte;
    logic [7:0] high_part;
    logic [7:0] low_part;
    logic       status;
    logic       busy_res;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_WIPE, ST_IDLE, ST_LOOP_RD, ST_LOOP_WR, ST_TICK_RD, ST_TICK_CMP, ST_FRAME, ST_STATUS
  } state_t;

  typedef enum logic [2:0] {
    FS_OFF, FS_ROW, FS_COL, FS_HI, FS_LO, FS_ON
  } fstep_t;

  function automatic out_t make_frame(input logic data, input logic [7:0] payload,
                                      input logic busy);
    out_t o;
    o.kind      = 1'b1;
    o.sync_byte = data ? SYNC_DATA : SYNC_CMD;
    o.high_part = {payload[7:4], 4'h0};
    o.low_part  = {payload[3:0], 4'h0};
    o.status    = 1'b0;
    o.busy_res  = busy;
    o.last      = 1'b0;
    return o;
  endfunction

endpackage

FILE: hdl/mlcd_out_reg.sv
module mlcd_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mlcd_pkg::out_t  push_data,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_stall,
  output mlcd_pkg::out_t  out_data
);

  // Free when empty or when the held item leaves this cycle
  assign can_push = !out_valid || !out_stall;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_push) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      out_data <= push_data;
    end
  end

endmodule

FILE: hdl/mono_lcd_framebuffer_dirty_flush.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid / in_stall  | in_data (opcode, row, col, value)
// out     | out | out_valid / out_stall| out_data (kind .. last)
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
// After reset a wipe zeroes all 512 words of both buffers; no item is taken meanwhile.
// Each buffer word is read, then written, through the single memory ports:
// pixel 1 word, row ops 8, column 64, clear 512; the item is accepted when idle
// and ends with a status result.
// A tick during a flush is accepted when idle, read in ST_TICK_RD, compared in
// ST_TICK_CMP, emits its frames, then the status; an idle tick gives status only.
// A stalled output holds the FSM at its next result; input is taken only when idle.
`include "mono_lcd_framebuffer_dirty_flush_defines.svh"

module mono_lcd_framebuffer_dirty_flush (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mlcd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mlcd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  logic [7:0] function_set_code;
  logic [7:0] gdram_address_code;
  logic [7:0] clear_fill;

  mlcd_pkg::state_t state, state_next;
  mlcd_pkg::fstep_t fstep, fstep_next;

  logic [2:0] op;
  logic [5:0] row;
  logic [6:0] col;
  logic       lit;
  logic [mlcd_pkg::ADDR_W-1:0] idx, idx_next;
  logic       rej, rej_next;
  logic       flush_active, flush_active_next;
  logic       force_mode, force_mode_next;
  logic       display_off_sent, display_off_sent_next;
  logic [mlcd_pkg::ADDR_W-1:0] scan_pos, scan_pos_next;
  logic [15:0] word, word_next;

  logic [15:0] front_mem [mlcd_pkg::WORD_COUNT];
  logic [15:0] shadow_mem [mlcd_pkg::WORD_COUNT];
  logic [mlcd_pkg::ADDR_W-1:0] front_raddr, front_waddr, shadow_raddr, shadow_waddr;
  logic [15:0] front_rdata, shadow_rdata, front_wdata, shadow_wdata;
  logic        front_we, shadow_we;

  logic           push, can_push;
  mlcd_pkg::out_t push_data;
  logic           in_take;
  logic [mlcd_pkg::ADDR_W-1:0] loop_addr, loop_last;
  logic [15:0]    bit_mask, loop_wdata;
  logic [7:0]     frame_payload;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != mlcd_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      function_set_code  <= 8'h30;
      gdram_address_code <= 8'h80;
      clear_fill         <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlcd_pkg::CFG_FUNCTION_SET: function_set_code  <= cfg_data;
        mlcd_pkg::CFG_GDRAM_ADDR:   gdram_address_code <= cfg_data;
        mlcd_pkg::CFG_CLEAR_FILL:   clear_fill         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Buffer memories
  always_ff @(posedge clk) begin
    if (front_we) begin
      front_mem[front_waddr] <= front_wdata;
    end
    front_rdata <= front_mem[front_raddr];
  end

  always_ff @(posedge clk) begin
    if (shadow_we) begin
      shadow_mem[shadow_waddr] <= shadow_wdata;
    end
    shadow_rdata <= shadow_mem[shadow_raddr];
  end

  // Address and data of the current drawing step
  assign bit_mask = 16'h8000 >> col[3:0];

  always_comb begin
    unique case (op)
      mlcd_pkg::OP_PIXEL: begin
        loop_addr = {row, col[6:4]};
        loop_last = '0;
      end
      mlcd_pkg::OP_VLINE: begin
        loop_addr = {idx[5:0], col[6:4]};
        loop_last = 9'd63;
      end
      mlcd_pkg::OP_CLEAR: begin
        loop_addr = idx;
        loop_last = 9'd511;
      end
      default: begin
        loop_addr = {row, idx[2:0]};
        loop_last = 9'd7;
      end
    endcase
  end

  always_comb begin
    unique case (op)
      mlcd_pkg::OP_HLINE:  loop_wdata = lit ? 16'hffff : 16'h0000;
      mlcd_pkg::OP_INVERT: loop_wdata = ~front_rdata;
      mlcd_pkg::OP_CLEAR:  loop_wdata = {clear_fill, clear_fill};
      default:             loop_wdata = lit ? (front_rdata | bit_mask)
                                            : (front_rdata & ~bit_mask);
    endcase
  end

  // Frame payload for the current step
  always_comb begin
    unique case (fstep)
      mlcd_pkg::FS_OFF: frame_payload = function_set_code | mlcd_pkg::DISP_OFF_BITS;
      mlcd_pkg::FS_ROW: frame_payload = gdram_address_code | {3'b000, scan_pos[7:3]};
      mlcd_pkg::FS_COL: frame_payload = gdram_address_code | {4'h0, scan_pos[8], scan_pos[2:0]};
      mlcd_pkg::FS_HI:  frame_payload = word[15:8];
      mlcd_pkg::FS_LO:  frame_payload = word[7:0];
      mlcd_pkg::FS_ON:  frame_payload = function_set_code | mlcd_pkg::DISP_ON_BITS;
      default:          frame_payload = 8'h00;
    endcase
  end

  // Sequencer: next state, memory controls and result pushes
  always_comb begin
    state_next            = state;
    fstep_next            = fstep;
    idx_next              = idx;
    rej_next              = rej;
    flush_active_next     = flush_active;
    force_mode_next       = force_mode;
    display_off_sent_next = display_off_sent;
    scan_pos_next         = scan_pos;
    word_next             = word;
    front_raddr  = loop_addr;
    shadow_raddr = scan_pos;
    front_waddr  = loop_addr;
    shadow_waddr = scan_pos;
    front_wdata  = loop_wdata;
    shadow_wdata = front_rdata;
    front_we     = 1'b0;
    shadow_we    = 1'b0;
    push         = 1'b0;
    push_data    = mlcd_pkg::make_frame(fstep == mlcd_pkg::FS_HI || fstep == mlcd_pkg::FS_LO,
                                        frame_payload, fstep != mlcd_pkg::FS_ON);

    unique case (state)
      mlcd_pkg::ST_WIPE: begin
        front_waddr  = idx;
        shadow_waddr = idx;
        front_wdata  = '0;
        shadow_wdata = '0;
        front_we     = 1'b1;
        shadow_we    = 1'b1;
        idx_next     = idx + 9'd1;
        if (idx == 9'd511) begin
          state_next = mlcd_pkg::ST_IDLE;
        end
      end
      mlcd_pkg::ST_IDLE: begin
        idx_next = '0;
        rej_next = 1'b0;
        if (in_take) begin
          if (in_data.opcode == mlcd_pkg::OP_TICK) begin
            state_next = flush_active ? mlcd_pkg::ST_TICK_RD : mlcd_pkg::ST_STATUS;
          end else if (flush_active) begin
            rej_next   = 1'b1;
            state_next = mlcd_pkg::ST_STATUS;
          end else if (in_data.opcode == mlcd_pkg::OP_FLUSH ||
                       in_data.opcode == mlcd_pkg::OP_FORCE) begin
            flush_active_next     = 1'b1;
            force_mode_next       = (in_data.opcode == mlcd_pkg::OP_FORCE);
            display_off_sent_next = 1'b0;
            scan_pos_next         = '0;
            state_next            = mlcd_pkg::ST_STATUS;
          end else begin
            state_next = mlcd_pkg::ST_LOOP_RD;
          end
        end
      end
      mlcd_pkg::ST_LOOP_RD: begin
        state_next = mlcd_pkg::ST_LOOP_WR;
      end
      mlcd_pkg::ST_LOOP_WR: begin
        front_we = 1'b1;
        idx_next = idx + 9'd1;
        state_next = (idx == loop_last) ? mlcd_pkg::ST_STATUS : mlcd_pkg::ST_LOOP_RD;
      end
      mlcd_pkg::ST_TICK_RD: begin
        front_raddr = scan_pos;
        state_next  = mlcd_pkg::ST_TICK_CMP;
      end
      mlcd_pkg::ST_TICK_CMP: begin
        word_next = front_rdata;
        if (force_mode || front_rdata != shadow_rdata) begin
          shadow_we  = 1'b1;
          fstep_next = display_off_sent ? mlcd_pkg::FS_ROW : mlcd_pkg::FS_OFF;
          state_next = mlcd_pkg::ST_FRAME;
        end else if (scan_pos == 9'd511 && display_off_sent) begin
          fstep_next = mlcd_pkg::FS_ON;
          state_next = mlcd_pkg::ST_FRAME;
        end else begin
          scan_pos_next = scan_pos + 9'd1;
          if (scan_pos == 9'd511) begin
            flush_active_next = 1'b0;
            force_mode_next   = 1'b0;
          end
          state_next = mlcd_pkg::ST_STATUS;
        end
      end
      mlcd_pkg::ST_FRAME: begin
        if (can_push) begin
          push = 1'b1;
          unique case (fstep)
            mlcd_pkg::FS_OFF: begin
              display_off_sent_next = 1'b1;
              fstep_next = mlcd_pkg::FS_ROW;
            end
            mlcd_pkg::FS_ROW: fstep_next = mlcd_pkg::FS_COL;
            mlcd_pkg::FS_COL: fstep_next = mlcd_pkg::FS_HI;
            mlcd_pkg::FS_HI:  fstep_next = mlcd_pkg::FS_LO;
            mlcd_pkg::FS_LO: begin
              if (scan_pos == 9'd511) begin
                fstep_next = mlcd_pkg::FS_ON;
              end else begin
                scan_pos_next = scan_pos + 9'd1;
                state_next    = mlcd_pkg::ST_STATUS;
              end
            end
            default: begin
              flush_active_next     = 1'b0;
              force_mode_next       = 1'b0;
              display_off_sent_next = 1'b0;
              scan_pos_next         = '0;
              state_next            = mlcd_pkg::ST_STATUS;
            end
          endcase
        end
      end
      default: begin
        push_data          = '0;
        push_data.status   = rej;
        push_data.busy_res = flush_active;
        push_data.last     = 1'b1;
        if (can_push) begin
          push       = 1'b1;
          state_next = mlcd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= mlcd_pkg::ST_WIPE;
      fstep            <= mlcd_pkg::FS_OFF;
      idx              <= '0;
      rej              <= 1'b0;
      flush_active     <= 1'b0;
      force_mode       <= 1'b0;
      display_off_sent <= 1'b0;
      scan_pos         <= '0;
    end else begin
      state            <= state_next;
      fstep            <= fstep_next;
      idx              <= idx_next;
      rej              <= rej_next;
      flush_active     <= flush_active_next;
      force_mode       <= force_mode_next;
      display_off_sent <= display_off_sent_next;
      scan_pos         <= scan_pos_next;
    end
  end

  // Captured item and word under transfer
  always_ff @(posedge clk) begin
    if (in_take) begin
      op  <= in_data.opcode;
      row <= in_data.row[5:0];
      col <= in_data.col[6:0];
      lit <= in_data.value;
    end
    word <= word_next;
  end

  mlcd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MLCD_ASSERT(a_off_needs_flush, !flush_active |-> !display_off_sent, "off sent while idle")
  `MLCD_ASSERT(a_force_needs_flush, force_mode |-> flush_active, "force mode while idle")
  `MLCD_ASSERT(a_scan_needs_flush, (scan_pos != '0) |-> flush_active, "scan moved while idle")
  `MLCD_ASSERT(a_no_draw_in_flush, front_we |-> (!flush_active || state == mlcd_pkg::ST_WIPE),
               "front buffer written during flush")

endmodule

FILE: tb/tb_mono_lcd_framebuffer_dirty_flush.sv
module tb_mono_lcd_framebuffer_dirty_flush;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame buffer predictor: mirrors buffers, flush scan and registers, and
  // keeps the results still owed by the block.
  class lcd_flush_predictor;
    logic [7:0]  fn_code = 8'h30;
    logic [7:0]  addr_code = 8'h80;
    logic [7:0]  fill_byte = 8'h00;
    logic [15:0] front [mlcd_pkg::WORD_COUNT];
    logic [15:0] shadow [mlcd_pkg::WORD_COUNT];
    int unsigned scan_pos = 0;
    bit          flushing = 0;
    bit          forced = 0;
    bit          off_sent = 0;
    mlcd_pkg::out_t owed [$];
    int          mismatches = 0;

    function void clear_buffers();
      foreach (front[i]) begin
        front[i] = '0;
        shadow[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        mlcd_pkg::CFG_FUNCTION_SET: fn_code = data;
        mlcd_pkg::CFG_GDRAM_ADDR:   addr_code = data;
        mlcd_pkg::CFG_CLEAR_FILL:   fill_byte = data;
        default: ;
      endcase
    endfunction

    function void push_frame(bit data, logic [7:0] payload, bit busy);
      mlcd_pkg::out_t o;
      o.kind = 1'b1;
      o.sync_byte = data ? mlcd_pkg::SYNC_DATA : mlcd_pkg::SYNC_CMD;
      o.high_part = payload & 8'hf0;
      o.low_part = {payload[3:0], 4'h0};
      o.status = 1'b0;
      o.busy_res = busy;
      o.last = 1'b0;
      owed.push_back(o);
    endfunction

    function void push_status(bit rejected);
      mlcd_pkg::out_t o;
      o = '0;
      o.status = rejected;
      o.busy_res = flushing;
      o.last = 1'b1;
      owed.push_back(o);
    endfunction

    // Advance the scan by one buffer word.
    function void scan_tick();
      int unsigned prow;
      int unsigned pword;
      logic [15:0] w;
      prow = scan_pos / 8;
      pword = scan_pos % 8;
      if (forced || front[scan_pos] != shadow[scan_pos]) begin
        w = front[scan_pos];
        if (!off_sent) begin
          push_frame(1'b0, fn_code | mlcd_pkg::DISP_OFF_BITS, 1'b1);
          off_sent = 1;
        end
        push_frame(1'b0, addr_code | 8'(prow % 32), 1'b1);
        push_frame(1'b0, addr_code | 8'(pword + (prow > 31 ? 8 : 0)), 1'b1);
        push_frame(1'b1, w[15:8], 1'b1);
        push_frame(1'b1, w[7:0], 1'b1);
        shadow[scan_pos] = w;
      end
      scan_pos++;
      if (scan_pos >= mlcd_pkg::WORD_COUNT) begin
        if (off_sent) push_frame(1'b0, fn_code | mlcd_pkg::DISP_ON_BITS, 1'b0);
        flushing = 0;
        forced = 0;
        off_sent = 0;
        scan_pos = 0;
      end
    endfunction

    function void note_accepted(mlcd_pkg::in_t it);
      int unsigned r;
      int unsigned c;
      logic [15:0] bitmask;
      int unsigned widx;
      r = it.row % 64;
      c = it.col % 128;
      bitmask = 16'h8000 >> (c % 16);
      widx = r * 8 + c / 16;
      if (it.opcode == mlcd_pkg::OP_TICK) begin
        if (flushing) scan_tick();
        push_status(1'b0);
        return;
      end
      if (flushing) begin
        push_status(1'b1);
        return;
      end
      case (it.opcode)
        mlcd_pkg::OP_PIXEL:
          front[widx] = it.value ? (front[widx] | bitmask) : (front[widx] & ~bitmask);
        mlcd_pkg::OP_HLINE:
          for (int i = 0; i < 8; i++) front[r * 8 + i] = it.value ? 16'hffff : 16'h0000;
        mlcd_pkg::OP_VLINE:
          for (int i = 0; i < 64; i++) begin
            if (it.value) front[i * 8 + c / 16] |= bitmask;
            else front[i * 8 + c / 16] &= ~bitmask;
          end
        mlcd_pkg::OP_INVERT:
          for (int i = 0; i < 8; i++) front[r * 8 + i] ^= 16'hffff;
        mlcd_pkg::OP_CLEAR:
          foreach (front[i]) front[i] = {fill_byte, fill_byte};
        default: begin
          flushing = 1;
          forced = (it.opcode == mlcd_pkg::OP_FORCE);
          off_sent = 0;
          scan_pos = 0;
        end
      endcase
      push_status(1'b0);
    endfunction

    function void check_result(mlcd_pkg::out_t got);
      mlcd_pkg::out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind || got.sync_byte !== want.sync_byte ||
          got.high_part !== want.high_part || got.low_part !== want.low_part ||
          got.status !== want.status || got.busy_res !== want.busy_res ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected k%b s%h h%h l%h st%b b%b L%b,",
                    " got k%b s%h h%h l%h st%b b%b L%b"},
                   want.kind, want.sync_byte, want.high_part, want.low_part,
                   want.status, want.busy_res, want.last,
                   got.kind, got.sync_byte, got.high_part, got.low_part,
                   got.status, got.busy_res, got.last);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  mlcd_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  mlcd_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [7:0]     cfg_data = '0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  lcd_flush_predictor pred;

  mono_lcd_framebuffer_dirty_flush dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Check each result transfer and pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pred.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(mlcd_pkg::in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pred.note_accepted(it);
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] r, logic [7:0] c, logic v);
    mlcd_pkg::in_t it;
    it.opcode = op;
    it.row = r;
    it.col = c;
    it.value = v;
    send_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred.write_reg(idx, data);
  endtask

  // Random drawing op or idle tick; clear is kept rare since it is slow.
  task automatic send_random_draw();
    int unsigned pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 40) op = mlcd_pkg::OP_PIXEL;
    else if (pick < 55) op = mlcd_pkg::OP_HLINE;
    else if (pick < 67) op = mlcd_pkg::OP_VLINE;
    else if (pick < 85) op = mlcd_pkg::OP_INVERT;
    else if (pick < 88) op = mlcd_pkg::OP_CLEAR;
    else op = mlcd_pkg::OP_TICK;
    send_op(op, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Tick the flush along, with some rejected noise mixed in.
  task automatic send_flush_traffic(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 95)
        send_op(mlcd_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_op(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pred.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    #40ms;
    $display("tb_mono_lcd_framebuffer_dirty_flush: done, errors");
    $finish;
  end

  initial begin
    logic [7:0] fn_set [4];
    logic [7:0] addr_set [4];
    logic [7:0] fill_set [4];
    int unsigned gap_set [4];
    int unsigned stall_set [4];
    pred = new;
    pred.clear_buffers();
    fn_set = '{8'h30, 8'h00, 8'hff, 8'($urandom)};
    addr_set = '{8'h80, 8'hff, 8'h00, 8'($urandom)};
    fill_set = '{8'h00, 8'ha5, 8'hff, 8'($urandom)};
    gap_set = '{0, 72, 0, 6};
    stall_set = '{0, 0, 72, 6};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_set[ph];
      stall_pct = stall_set[ph];
      write_reg(mlcd_pkg::CFG_FUNCTION_SET, fn_set[ph]);
      write_reg(mlcd_pkg::CFG_GDRAM_ADDR, addr_set[ph]);
      write_reg(mlcd_pkg::CFG_CLEAR_FILL, fill_set[ph]);

      if (ph == 0) begin
        // Directed: field extremes, every drawing op, idle tick.
        send_op(mlcd_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_PIXEL, 8'h00, 8'h00, 1'b1);
        send_op(mlcd_pkg::OP_PIXEL, 8'hff, 8'hff, 1'b1);
        send_op(mlcd_pkg::OP_PIXEL, 8'h3f, 8'h7f, 1'b0);
        send_op(mlcd_pkg::OP_PIXEL, 8'h20, 8'h0f, 1'b1);
        send_op(mlcd_pkg::OP_HLINE, 8'h00, 8'h00, 1'b1);
        send_op(mlcd_pkg::OP_HLINE, 8'hc1, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_VLINE, 8'h00, 8'h7f, 1'b1);
        send_op(mlcd_pkg::OP_VLINE, 8'h00, 8'h80, 1'b0);
        send_op(mlcd_pkg::OP_INVERT, 8'h3f, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_INVERT, 8'h40, 8'hff, 1'b1);
        send_op(mlcd_pkg::OP_CLEAR, 8'h00, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_PIXEL, 8'h25, 8'h33, 1'b1);
        send_op(mlcd_pkg::OP_PIXEL, 8'h00, 8'h13, 1'b1);
        for (int n = 0; n < 26; n++) send_random_draw();
      end else if (ph == 1) begin
        // Draw, start a flush, then try to draw and restart while busy.
        for (int n = 0; n < 50; n++) send_random_draw();
        send_op(mlcd_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_PIXEL, 8'h01, 8'h01, 1'b1);
        send_op(mlcd_pkg::OP_CLEAR, 8'h00, 8'h00, 1'b1);
        send_op(mlcd_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0);
        send_op(mlcd_pkg::OP_FORCE, 8'h00, 8'h00, 1'b0);
        send_flush_traffic(20);
      end else begin
        send_flush_traffic(130);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    stall_pct = 0;
    wait_drained();
    if (pred.mismatches == 0)
      $display("tb_mono_lcd_framebuffer_dirty_flush: done, clean");
    else
      $display("tb_mono_lcd_framebuffer_dirty_flush: done, errors");
    $finish;
  end
endmodule
